// ----- rtl/core/pap_pkg.sv -----
// peer address picker: shared types and constants
// no dependencies; compiled first

package pap_pkg;

    localparam int ADDR_W = 32;
    localparam int RAND_W = 32;
    localparam int OP_W   = 2;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [RAND_W-1:0] rand_t;

    localparam op_t OP_LOAD  = 2'd0;
    localparam op_t OP_PICK  = 2'd1;
    localparam op_t OP_RESET = 2'd2;
    localparam op_t OP_NOP   = 2'd3;

endpackage

// ----- rtl/core/pap_if.sv -----
// peer address picker: request, response and configuration channels
// depends on pap_pkg

interface pap_req_if
    import pap_pkg::*;
    ();
    logic  valid;
    logic  ready;
    op_t   operation;
    addr_t addr_value;
    logic  entry_valid;
    logic  last_entry;
    rand_t rand_value;

    modport source (output valid, operation, addr_value, entry_valid, last_entry, rand_value,
                    input ready);
    modport sink (input valid, operation, addr_value, entry_valid, last_entry, rand_value,
                  output ready);
endinterface

interface pap_rsp_if
    import pap_pkg::*;
    ();
    logic  valid;
    logic  ready;
    logic  has_next;
    addr_t picked_addr;
    logic  same_as_current;
    addr_t current_addr;

    modport source (output valid, has_next, picked_addr, same_as_current, current_addr,
                    input ready);
    modport sink (input valid, has_next, picked_addr, same_as_current, current_addr,
                  output ready);
endinterface

interface pap_cfg_if
    import pap_pkg::*;
    ();
    logic valid;
    logic ready;
    logic select_mode;

    modport source (output valid, select_mode, input ready);
    modport sink (input valid, select_mode, output ready);
endinterface

// ----- rtl/core/peer_address_picker_top.sv -----
// peer address picker top: sequencer, tried flags, last-pick state, output register
// depends on pap_pkg, pap_if, pap_rem, pap_table
//
//   channel | dir | transfer carries
//   --------+-----+------------------------------------------------------------
//   req     | in  | operation, addr_value, entry_valid, last_entry, rand_value
//   rsp     | out | has_next, picked_addr, same_as_current, current_addr
//   cfg     | in  | select_mode
//
// one request at a time; load and reset-pick run a table scan (skipped with nothing to scan),
// round-robin pick searches on from the last pick, random pick counts the untried entries, takes
// the bit-serial remainder and then searches; a no-op goes straight to the response
// reset clears counts, tried flags and last pick; table contents need no clearing
// a waiting response does not block a new request; a finished one waits for the slot

module peer_address_picker_top
    import pap_pkg::*;
#(
    parameter int MAX_PEERS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    pap_req_if.sink   req,
    pap_rsp_if.source rsp,
    pap_cfg_if.sink   cfg
);

    localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CW = $clog2(MAX_PEERS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PEERS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_CNT  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIND = 3'd4;
    localparam logic [2:0] S_READ = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    logic [2:0]           state_reg, state_next;
    op_t                  op_reg, op_next;
    addr_t                addr_reg, addr_next;
    logic                 last_reg, last_next;
    rand_t                rnd_reg, rnd_next;
    logic                 bank_reg, bank_next;
    logic [CW-1:0]        peer_cnt_reg, peer_cnt_next;
    logic [CW-1:0]        stg_cnt_reg, stg_cnt_next;
    logic [MAX_PEERS-1:0] tried_reg, tried_next;
    logic [IW-1:0]        last_idx_reg, last_idx_next;
    logic                 last_vld_reg, last_vld_next;
    addr_t                cur_addr_reg, cur_addr_next;
    logic                 all_found_reg, all_found_next;
    logic                 sel_mode_reg, sel_mode_next;
    logic [CW-1:0]        scan_n_reg, scan_n_next;
    logic                 scan_wr_reg, scan_wr_next;
    logic [CW-1:0]        issue_cnt_reg, issue_cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [IW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 match_reg, match_next;
    logic [IW-1:0]        k_reg, k_next;
    logic [CW-1:0]        step_reg, step_next;
    logic [CW-1:0]        avail_reg, avail_next;
    logic [CW-1:0]        seen_reg, seen_next;
    logic                 res_has_reg, res_has_next;
    addr_t                res_pick_reg, res_pick_next;
    logic                 res_same_reg, res_same_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic                 rsp_has_reg, rsp_has_next;
    addr_t                rsp_picked_reg, rsp_picked_next;
    logic                 rsp_same_reg, rsp_same_next;
    addr_t                rsp_cur_reg, rsp_cur_next;

    logic          wr_en;
    logic          wr_bank;
    logic [IW-1:0] wr_idx;
    logic          rd_en;
    logic [IW-1:0] rd_idx;
    addr_t         rd_data;
    logic          rem_start;
    logic          rem_done;
    logic [CW-1:0] rem_val;

    logic          load_wr;
    logic [CW-1:0] start_inc;
    logic [CW-1:0] seq_start;
    logic          k_wrap;

    assign load_wr   = req.entry_valid && (stg_cnt_reg < MAX_CNT);
    assign start_inc = CW'(last_idx_reg) + 1'b1;
    assign seq_start = (last_vld_reg && (start_inc < peer_cnt_reg)) ? start_inc : '0;
    assign k_wrap    = (CW'(k_reg) + 1'b1) == peer_cnt_reg;
    assign wr_bank   = ~bank_reg;
    assign wr_idx    = stg_cnt_reg[IW-1:0];

    pap_table #(
        .DEPTH (MAX_PEERS),
        .IW    (IW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_bank (wr_bank),
        .wr_idx  (wr_idx),
        .wr_data (req.addr_value),
        .rd_en   (rd_en),
        .rd_bank (bank_reg),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    pap_rem #(
        .DW (CW)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (rnd_reg),
        .divisor   (avail_reg),
        .done      (rem_done),
        .remainder (rem_val)
    );

    always_comb
    begin
        logic af;
        logic same;

        af   = 1'b0;
        same = 1'b0;

        state_next      = state_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        last_next       = last_reg;
        rnd_next        = rnd_reg;
        bank_next       = bank_reg;
        peer_cnt_next   = peer_cnt_reg;
        stg_cnt_next    = stg_cnt_reg;
        tried_next      = tried_reg;
        last_idx_next   = last_idx_reg;
        last_vld_next   = last_vld_reg;
        cur_addr_next   = cur_addr_reg;
        all_found_next  = all_found_reg;
        sel_mode_next   = sel_mode_reg;
        scan_n_next     = scan_n_reg;
        scan_wr_next    = scan_wr_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_pend_next    = rd_pend_reg;
        rd_idx_next     = rd_idx_reg;
        match_next      = match_reg;
        k_next          = k_reg;
        step_next       = step_reg;
        avail_next      = avail_reg;
        seen_next       = seen_reg;
        res_has_next    = res_has_reg;
        res_pick_next   = res_pick_reg;
        res_same_next   = res_same_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_has_next    = rsp_has_reg;
        rsp_picked_next = rsp_picked_reg;
        rsp_same_next   = rsp_same_reg;
        rsp_cur_next    = rsp_cur_reg;

        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rd_idx    = issue_cnt_reg[IW-1:0];
        rem_start = 1'b0;

        if (cfg.valid)
        begin
            sel_mode_next = cfg.select_mode;
        end

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next        = req.operation;
                    addr_next      = req.addr_value;
                    last_next      = req.last_entry;
                    rnd_next       = req.rand_value;
                    res_has_next   = 1'b0;
                    res_pick_next  = '0;
                    res_same_next  = 1'b0;
                    issue_cnt_next = '0;
                    rd_pend_next   = 1'b0;
                    match_next     = 1'b0;
                    step_next      = '0;
                    k_next         = '0;
                    avail_next     = '0;
                    seen_next      = '0;
                    scan_wr_next   = 1'b0;
                    scan_n_next    = '0;
                    unique case (req.operation)
                        OP_LOAD:
                        begin
                            scan_wr_next = load_wr;
                            if (load_wr)
                            begin
                                wr_en        = 1'b1;
                                stg_cnt_next = stg_cnt_reg + 1'b1;
                                scan_n_next  = peer_cnt_reg;
                            end
                            state_next = S_SCAN;
                        end
                        OP_PICK:
                        begin
                            if (peer_cnt_reg == '0)
                            begin
                                state_next = S_RESP;
                            end
                            else if (sel_mode_reg)
                            begin
                                state_next = S_CNT;
                            end
                            else
                            begin
                                k_next     = seq_start[IW-1:0];
                                state_next = S_FIND;
                            end
                        end
                        OP_RESET:
                        begin
                            scan_n_next = peer_cnt_reg;
                            state_next  = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (issue_cnt_reg < scan_n_reg)
                begin
                    rd_en          = 1'b1;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    rd_pend_next   = 1'b1;
                    rd_idx_next    = issue_cnt_reg[IW-1:0];
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end

                if (rd_pend_reg)
                begin
                    if (rd_data == addr_reg)
                    begin
                        match_next = 1'b1;
                        if (op_reg == OP_RESET)
                        begin
                            last_idx_next = rd_idx_reg;
                        end
                    end
                    if (op_reg == OP_RESET)
                    begin
                        tried_next[rd_idx_reg] = (rd_data == addr_reg);
                    end
                end

                if ((issue_cnt_reg == scan_n_reg) && !rd_pend_reg)
                begin
                    state_next = S_RESP;
                    if (op_reg == OP_RESET)
                    begin
                        last_vld_next = match_reg;
                        cur_addr_next = addr_reg;
                    end
                    else
                    begin
                        af = all_found_reg & (~scan_wr_reg | match_reg);
                        if (last_reg)
                        begin
                            same          = af && (stg_cnt_reg == peer_cnt_reg);
                            res_same_next = same;
                            if (!same)
                            begin
                                bank_next     = ~bank_reg;
                                peer_cnt_next = stg_cnt_reg;
                                last_vld_next = 1'b0;
                            end
                            tried_next     = '0;
                            stg_cnt_next   = '0;
                            all_found_next = 1'b1;
                        end
                        else
                        begin
                            all_found_next = af;
                        end
                    end
                end
            end

            S_CNT:
            begin
                if (step_reg == peer_cnt_reg)
                begin
                    if (avail_reg == '0)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        rem_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    if (!tried_reg[step_reg[IW-1:0]])
                    begin
                        avail_next = avail_reg + 1'b1;
                    end
                    step_next = step_reg + 1'b1;
                end
            end

            S_DIV:
            begin
                if (rem_done)
                begin
                    step_next  = '0;
                    k_next     = '0;
                    seen_next  = '0;
                    state_next = S_FIND;
                end
            end

            S_FIND:
            begin
                if (step_reg == peer_cnt_reg)
                begin
                    state_next = S_RESP;
                end
                else if (!tried_reg[k_reg] && (!sel_mode_reg || (seen_reg == rem_val)))
                begin
                    tried_next[k_reg] = 1'b1;
                    last_idx_next     = k_reg;
                    last_vld_next     = 1'b1;
                    rd_en             = 1'b1;
                    rd_idx            = k_reg;
                    state_next        = S_READ;
                end
                else
                begin
                    if (!tried_reg[k_reg])
                    begin
                        seen_next = seen_reg + 1'b1;
                    end
                    step_next = step_reg + 1'b1;
                    k_next    = k_wrap ? '0 : k_reg + 1'b1;
                end
            end

            S_READ:
            begin
                res_has_next  = 1'b1;
                res_pick_next = rd_data;
                cur_addr_next = rd_data;
                state_next    = S_RESP;
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_has_next    = res_has_reg;
                    rsp_picked_next = res_pick_reg;
                    rsp_same_next   = res_same_reg;
                    rsp_cur_next    = last_vld_reg ? cur_addr_reg : '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bank_reg      <= 1'b0;
            peer_cnt_reg  <= '0;
            stg_cnt_reg   <= '0;
            tried_reg     <= '0;
            last_idx_reg  <= '0;
            last_vld_reg  <= 1'b0;
            all_found_reg <= 1'b1;
            sel_mode_reg  <= 1'b0;
            scan_n_reg    <= '0;
            scan_wr_reg   <= 1'b0;
            issue_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            match_reg     <= 1'b0;
            k_reg         <= '0;
            step_reg      <= '0;
            avail_reg     <= '0;
            seen_reg      <= '0;
            res_has_reg   <= 1'b0;
            res_same_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            peer_cnt_reg  <= peer_cnt_next;
            stg_cnt_reg   <= stg_cnt_next;
            tried_reg     <= tried_next;
            last_idx_reg  <= last_idx_next;
            last_vld_reg  <= last_vld_next;
            all_found_reg <= all_found_next;
            sel_mode_reg  <= sel_mode_next;
            scan_n_reg    <= scan_n_next;
            scan_wr_reg   <= scan_wr_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            rd_idx_reg    <= rd_idx_next;
            match_reg     <= match_next;
            k_reg         <= k_next;
            step_reg      <= step_next;
            avail_reg     <= avail_next;
            seen_reg      <= seen_next;
            res_has_reg   <= res_has_next;
            res_same_reg  <= res_same_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        last_reg       <= last_next;
        rnd_reg        <= rnd_next;
        cur_addr_reg   <= cur_addr_next;
        res_pick_reg   <= res_pick_next;
        rsp_has_reg    <= rsp_has_next;
        rsp_picked_reg <= rsp_picked_next;
        rsp_same_reg   <= rsp_same_next;
        rsp_cur_reg    <= rsp_cur_next;
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign cfg.ready           = 1'b1;
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.has_next        = rsp_has_reg;
    assign rsp.picked_addr     = rsp_picked_reg;
    assign rsp.same_as_current = rsp_same_reg;
    assign rsp.current_addr    = rsp_cur_reg;

    // last pick always points inside the current list
    a_last_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        last_vld_reg |-> (CW'(last_idx_reg) < peer_cnt_reg))
        else $error("last pick index beyond peer count");

    // staging never exceeds the table depth
    a_stg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_cnt_reg <= MAX_CNT) && (peer_cnt_reg <= MAX_CNT))
        else $error("list count beyond table depth");

    // a successful pick becomes the current address
    a_pick_current: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_has_reg) |-> (rsp_cur_reg == rsp_picked_reg))
        else $error("picked address differs from current address");

    // remainder unit only runs with a nonzero untried count
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (avail_reg != '0))
        else $error("random pick with no untried entry");

endmodule

// ----- rtl/core/pap_rem.sv -----
// peer address picker: bit-serial remainder of the random word by the untried count
// depends on pap_pkg

module pap_rem
    import pap_pkg::*;
#(
    parameter int DW = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rand_t         dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] remainder
);

    localparam int SW = $clog2(RAND_W + 1);

    rand_t         shf_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] div_reg;
    logic [SW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   cand;
    logic [DW:0]   diff;
    logic          ge;

    assign cand = {rem_reg, shf_reg[RAND_W-1]};
    assign ge   = cand >= {1'b0, div_reg};
    assign diff = cand - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SW'(RAND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shf_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            shf_reg <= {shf_reg[RAND_W-2:0], 1'b0};
            rem_reg <= ge ? diff[DW-1:0] : cand[DW-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/core/pap_table.sv -----
// peer address picker: two-bank address store, one bank current, one staging
// depends on pap_pkg; one write port, one registered read port

module pap_table
    import pap_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int IW    = 3
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic          wr_bank,
    input  logic [IW-1:0] wr_idx,
    input  addr_t         wr_data,
    input  logic          rd_en,
    input  logic          rd_bank,
    input  logic [IW-1:0] rd_idx,
    output addr_t         rd_data
);

    addr_t mem [2][DEPTH];
    addr_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_bank][wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_bank][rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
